### rtl/mfpu_pkg.sv
// ----------------------------------------------------------------------------
// mfpu_pkg
// Shared types, register indexes and helpers of the compact float converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfpu_pkg;

  // Clamped widths in use by the datapath
  typedef struct packed {
    logic [3:0] ew;   // exponent field width, sign bit included (2..8)
    logic [4:0] mw;   // mantissa field width (2..23)
  } cfg_t;

  localparam logic REG_EXP_WIDTH = 1'b0;
  localparam logic REG_MAN_WIDTH = 1'b1;

  localparam logic [3:0] EW_RESET = 4'd5;
  localparam logic [4:0] MW_RESET = 5'd10;
  localparam logic [3:0] EW_MIN   = 4'd2;
  localparam logic [3:0] EW_MAX   = 4'd8;
  localparam logic [4:0] MW_MIN   = 5'd2;
  localparam logic [4:0] MW_MAX   = 5'd23;

  localparam logic [7:0] BIAS     = 8'd127;
  localparam logic [4:0] FRAC_W   = 5'd23;

  function automatic logic [31:0] mask32(input logic [4:0] n);
    mask32 = (32'd1 << n) - 32'd1;
  endfunction

endpackage

`default_nettype wire

### rtl/mfpu_cfg.sv
// ----------------------------------------------------------------------------
// mfpu_cfg
// Configuration registers behind an APB-style port, with width clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpu_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output mfpu_pkg::cfg_t      cfg
);

  logic [3:0] exp_width;
  logic [4:0] man_width;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_width <= mfpu_pkg::EW_RESET;
      man_width <= mfpu_pkg::MW_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        mfpu_pkg::REG_EXP_WIDTH: exp_width <= pwdata[3:0];
        mfpu_pkg::REG_MAN_WIDTH: man_width <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mfpu_pkg::REG_EXP_WIDTH: prdata = {28'd0, exp_width};
      mfpu_pkg::REG_MAN_WIDTH: prdata = {27'd0, man_width};
      default:                 prdata = 32'd0;
    endcase
  end

  always_comb begin
    priority if (exp_width < mfpu_pkg::EW_MIN) begin
      cfg.ew = mfpu_pkg::EW_MIN;
    end else if (exp_width > mfpu_pkg::EW_MAX) begin
      cfg.ew = mfpu_pkg::EW_MAX;
    end else begin
      cfg.ew = exp_width;
    end
    priority if (man_width < mfpu_pkg::MW_MIN) begin
      cfg.mw = mfpu_pkg::MW_MIN;
    end else if (man_width > mfpu_pkg::MW_MAX) begin
      cfg.mw = mfpu_pkg::MW_MAX;
    end else begin
      cfg.mw = man_width;
    end
  end

endmodule

`default_nettype wire

### rtl/mfpu_unpack.sv
// ----------------------------------------------------------------------------
// mfpu_unpack
// Rebuilds a float32 bit pattern from a compact code.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpu_unpack (
  input  wire logic [31:0]    code,
  input  mfpu_pkg::cfg_t      cfg,
  output logic      [31:0]    result
);

  logic [4:0]  bw;
  logic [4:0]  sign_pos;
  logic [4:0]  eneg_pos;
  logic [4:0]  frac_sh;
  logic [31:0] emag_full;
  logic [31:0] man_full;
  logic [6:0]  emag;
  logic        eneg;
  logic        sign;
  logic [7:0]  bexp;

  assign bw        = {1'b0, cfg.ew} - 5'd1;
  assign sign_pos  = {1'b0, cfg.ew} + cfg.mw;
  assign eneg_pos  = bw + cfg.mw;
  assign frac_sh   = mfpu_pkg::FRAC_W - cfg.mw;
  assign sign      = code[sign_pos];
  assign eneg      = code[eneg_pos];
  assign emag_full = (code >> cfg.mw) & mfpu_pkg::mask32(bw);
  assign emag      = emag_full[6:0];
  assign man_full  = (code & mfpu_pkg::mask32(cfg.mw)) << frac_sh;
  assign bexp      = eneg ? (mfpu_pkg::BIAS - {1'b0, emag})
                          : (mfpu_pkg::BIAS + {1'b0, emag});
  assign result    = {sign, bexp, man_full[22:0]};

endmodule

`default_nettype wire

### rtl/mfpu_pack.sv
// ----------------------------------------------------------------------------
// mfpu_pack
// Packs a float32 bit pattern into a compact code with saturation at both
// ends of the code range.
// ----------------------------------------------------------------------------
`default_nettype none

module mfpu_pack (
  input  wire logic [31:0]    x,
  input  mfpu_pkg::cfg_t      cfg,
  output logic      [31:0]    code
);

  logic [4:0]  bw;
  logic [4:0]  top_pos;
  logic [4:0]  frac_sh;
  logic [31:0] bmask;
  logic [31:0] mmask;
  logic [31:0] max_code;
  logic [31:0] min_code;
  logic [31:0] sign_bit;
  logic [31:0] sat_sign;
  logic [31:0] man_hi;
  logic [31:0] man_lo;
  logic [7:0]  bexp_max;
  logic [7:0]  bexp_min;
  logic [30:0] max_mag;
  logic [30:0] min_mag;
  logic [30:0] mag;
  logic        sign;
  logic        in_range;
  logic [7:0]  bexp;
  logic        eneg;
  logic [7:0]  emag;
  logic [31:0] exp_field;
  logic [31:0] frac_field;
  logic [31:0] plain;

  assign bw       = {1'b0, cfg.ew} - 5'd1;
  assign top_pos  = {1'b0, cfg.ew} + cfg.mw;
  assign frac_sh  = mfpu_pkg::FRAC_W - cfg.mw;
  assign bmask    = mfpu_pkg::mask32(bw);
  assign mmask    = mfpu_pkg::mask32(cfg.mw);

  assign max_code = (bmask << cfg.mw) | mmask;
  assign min_code = ((mfpu_pkg::mask32({1'b0, cfg.ew}) - 32'd1) << cfg.mw) | 32'd1;

  // Magnitudes of the largest and smallest codes once unpacked
  assign man_hi   = mmask << frac_sh;
  assign man_lo   = 32'd1 << frac_sh;
  assign bexp_max = mfpu_pkg::BIAS + bmask[7:0];
  assign bexp_min = (mfpu_pkg::BIAS + 8'd2) - (8'd1 << bw);
  assign max_mag  = {bexp_max, man_hi[22:0]};
  assign min_mag  = {bexp_min, man_lo[22:0]};

  assign mag      = x[30:0];
  assign sign     = x[31];
  assign in_range = (mag <= 31'h7F80_0000);
  assign sign_bit = {31'd0, sign} << top_pos;
  assign sat_sign = (mag == 31'd0) ? 32'd0 : sign_bit;

  assign bexp     = x[30:23];
  assign eneg     = (bexp < mfpu_pkg::BIAS);
  assign emag     = eneg ? (mfpu_pkg::BIAS - bexp) : (bexp - mfpu_pkg::BIAS);
  assign exp_field  = (({31'd0, eneg} << bw) | ({24'd0, emag} & bmask)) << cfg.mw;
  assign frac_field = {9'd0, x[22:0]} >> frac_sh;
  assign plain      = sign_bit | exp_field | frac_field;

  always_comb begin
    priority if (in_range && (mag >= max_mag)) begin
      code = max_code | sat_sign;
    end else if (in_range && (mag <= min_mag)) begin
      code = min_code | sat_sign;
    end else begin
      code = plain;
    end
  end

endmodule

`default_nettype wire

### rtl/minifloat_pack_unpack.sv
// ----------------------------------------------------------------------------
// minifloat_pack_unpack
// Converts float32 bit patterns to compact float codes and back.
// ----------------------------------------------------------------------------
// Input beats (op, operand) arrive on in_valid/in_ready; op 0 packs a float32
// pattern into a compact code, op 1 unpacks a compact code into float32.
// Result beats (converted) leave on out_valid/out_ready, one per input beat,
// in order.
// An accepted beat is held in the input register, converted in one pass
// of combinational logic, and captured in the result register. Throughput
// is one beat per cycle while the receiver keeps up; both pipeline registers
// advance together whenever the result register is empty or being taken.
// When the receiver stalls, the result register holds, then the input
// register fills, and only then does in_ready drop.
// Exponent and mantissa widths are set over the APB port and are clamped
// to 2..8 and 2..23; change them only while no beat is in flight.
// Reset empties both pipeline registers and restores widths of 5 and 10.
// ----------------------------------------------------------------------------
`default_nettype none

module minifloat_pack_unpack (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [31:0] operand,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] converted
);

  mfpu_pkg::cfg_t cfg;

  logic        stage_valid;
  logic        stage_op;
  logic [31:0] stage_operand;
  logic        stage_advance;
  logic [31:0] packed_code;
  logic [31:0] unpacked_float;

  mfpu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfpu_pack u_pack (
    .x    (stage_operand),
    .cfg  (cfg),
    .code (packed_code)
  );

  mfpu_unpack u_unpack (
    .code   (stage_operand),
    .cfg    (cfg),
    .result (unpacked_float)
  );

  assign stage_advance = !out_valid || out_ready;
  assign in_ready      = !stage_valid || stage_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_op      <= op;
      stage_operand <= operand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && stage_valid) begin
      converted <= stage_op ? unpacked_float : packed_code;
    end
  end

endmodule

`default_nettype wire
